FILE: rtl/lsfd_pkg.sv
package lsfd_pkg;

    // Field widths fixed by the item format
    localparam int SAMPLE_W = 16;
    localparam int COEF_W   = 16;
    localparam int RES_W    = 18;
    localparam int IDX_W    = 3;
    localparam int PROD_W   = COEF_W + SAMPLE_W;

    // Parameter defaults
    localparam int ORDER_DEF     = 5;
    localparam int FRAME_LEN_DEF = 20;
    localparam int COEF_FRAC_DEF = 12;

    typedef enum logic {
        KIND_COEF = 1'b0,
        KIND_RES  = 1'b1
    } t_kind;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [COEF_W-1:0]   t_coef;

    // Filter datapath result
    typedef struct packed {
        t_sample sample;
        logic    clipped;
    } t_mac_out;

endpackage

FILE: rtl/lsfd_mac.sv
module lsfd_mac #(
    parameter int ORDER          = lsfd_pkg::ORDER_DEF,
    parameter int COEF_FRAC_BITS = lsfd_pkg::COEF_FRAC_DEF
) (
    input  lsfd_pkg::t_coef                      i_coef [ORDER],
    input  lsfd_pkg::t_sample                    i_hist [ORDER],
    input  logic signed [lsfd_pkg::RES_W-1:0]    i_residual,
    output lsfd_pkg::t_mac_out                   o_result
);
    import lsfd_pkg::*;

    // Room for ORDER quotients plus the residual
    localparam int ACC_W = PROD_W + 1 + $clog2(ORDER + 1);
    localparam logic signed [PROD_W-1:0] BIAS    = PROD_W'((1 << COEF_FRAC_BITS) - 1);
    localparam logic signed [PROD_W-1:0] NO_BIAS = '0;
    localparam logic signed [ACC_W-1:0]  SAT_MAX = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0]  SAT_MIN = ACC_W'(-32768);

    logic signed [PROD_W-1:0] quot [ORDER];
    logic signed [ACC_W-1:0]  acc;

    // One multiplier per tap; quotient truncated toward zero
    always_comb begin
        logic signed [PROD_W-1:0] prod;
        for (int i = 0; i < ORDER; i++) begin
            prod    = i_coef[i] * i_hist[i];
            quot[i] = (prod + (prod[PROD_W-1] ? BIAS : NO_BIAS)) >>> COEF_FRAC_BITS;
        end
    end

    always_comb begin
        acc = ACC_W'(i_residual);
        for (int i = 0; i < ORDER; i++) begin
            acc = acc + ACC_W'(quot[i]);
        end
    end

    always_comb begin
        if (acc > SAT_MAX) begin
            o_result.sample  = t_sample'(16'sh7fff);
            o_result.clipped = 1'b1;
        end else if (acc < SAT_MIN) begin
            o_result.sample  = t_sample'(16'sh8000);
            o_result.clipped = 1'b1;
        end else begin
            o_result.sample  = acc[SAMPLE_W-1:0];
            o_result.clipped = 1'b0;
        end
    end

endmodule

FILE: rtl/lpc_synthesis_frame_decoder_top.sv
// All-pole LPC synthesis filter, one frame at a time.
// Input channel (i_valid / o_stall): a transaction with i_kind = coefficient
// loads i_coef_value into tap i_coef_index (indexes at or above ORDER are
// dropped) and produces nothing. A transaction with i_kind = residual
// produces one output transaction: the residual plus the prediction from
// the earlier samples of the current frame, saturated to 16 bits.
// Output channel (o_valid / i_stall): o_sample, o_frame_last on the final
// sample of each FRAME_LEN-sample frame, o_clipped when saturation hit.
// A residual enters the input register on acceptance; its sample is
// written to the output register when the stage fires. Throughput: one
// transaction per cycle unless the output stalls. The recursion is
// combinational: ORDER parallel 16x16 multipliers and the adder chain
// feed the history registers directly, so the next sample sees the new
// history. A coefficient load takes effect for the residual right behind it.
// When the receiver stalls, the output register holds; the input stage
// keeps moving while the output register is free or being drained, and
// o_stall rises only when a residual waits behind a stalled result.
// Coefficient transactions never wait on the output side.
// Reset (synchronous, active low) clears coefficients, history, the frame
// position and both valid flags.
module lpc_synthesis_frame_decoder_top #(
    parameter int ORDER          = lsfd_pkg::ORDER_DEF,
    parameter int FRAME_LEN      = lsfd_pkg::FRAME_LEN_DEF,
    parameter int COEF_FRAC_BITS = lsfd_pkg::COEF_FRAC_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // input channel
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic                                 i_kind,
    input  logic [lsfd_pkg::IDX_W-1:0]           i_coef_index,
    input  logic signed [lsfd_pkg::COEF_W-1:0]   i_coef_value,
    input  logic signed [lsfd_pkg::RES_W-1:0]    i_residual,
    // output channel
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic signed [lsfd_pkg::SAMPLE_W-1:0] o_sample,
    output logic                                 o_frame_last,
    output logic                                 o_clipped
);
    import lsfd_pkg::*;

    localparam int POS_W = (FRAME_LEN > 1) ? $clog2(FRAME_LEN) : 1;

    // Input register
    logic                     r_in_valid;
    t_kind                    r_in_kind;
    logic [IDX_W-1:0]         r_in_idx;
    t_coef                    r_in_coef;
    logic signed [RES_W-1:0]  r_in_res;

    // Filter state
    t_coef                    r_coef [ORDER];
    t_sample                  r_hist [ORDER];
    logic [POS_W-1:0]         r_pos;
    logic [POS_W-1:0]         n_pos;

    // Output register
    logic                     r_out_valid;
    t_sample                  r_out_sample;
    logic                     r_out_last;
    logic                     r_out_clip;

    logic                     out_free;
    logic                     s1_fire;
    logic                     res_fire;
    logic                     coef_fire;
    logic                     in_fire;
    logic                     frame_end;
    t_mac_out                 mac_out;

    lsfd_mac #(
        .ORDER          (ORDER),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_mac (
        .i_coef     (r_coef),
        .i_hist     (r_hist),
        .i_residual (r_in_res),
        .o_result   (mac_out)
    );

    // Handshake: the stage drains when the item is a coefficient load or the
    // output register can take a new sample this cycle.
    always_comb begin
        out_free  = !r_out_valid || !i_stall;
        s1_fire   = r_in_valid && (r_in_kind == KIND_COEF || out_free);
        res_fire  = s1_fire && r_in_kind == KIND_RES;
        coef_fire = s1_fire && r_in_kind == KIND_COEF;
        o_stall   = r_in_valid && !s1_fire;
        in_fire   = i_valid && !o_stall;
        frame_end = r_pos == POS_W'(FRAME_LEN - 1);
        n_pos     = frame_end ? '0 : r_pos + POS_W'(1);
    end

    // Control and filter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_pos       <= '0;
            for (int i = 0; i < ORDER; i++) begin
                r_coef[i] <= '0;
                r_hist[i] <= '0;
            end
        end else begin
            if (in_fire) begin
                r_in_valid <= 1'b1;
            end else if (s1_fire) begin
                r_in_valid <= 1'b0;
            end

            if (res_fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end

            if (coef_fire) begin
                for (int i = 0; i < ORDER; i++) begin
                    if (32'(r_in_idx) == i) begin
                        r_coef[i] <= r_in_coef;
                    end
                end
            end

            if (res_fire) begin
                r_pos <= n_pos;
                if (frame_end) begin
                    for (int i = 0; i < ORDER; i++) begin
                        r_hist[i] <= '0;
                    end
                end else begin
                    r_hist[0] <= mac_out.sample;
                    for (int i = 1; i < ORDER; i++) begin
                        r_hist[i] <= r_hist[i-1];
                    end
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in_kind <= t_kind'(i_kind);
            r_in_idx  <= i_coef_index;
            r_in_coef <= i_coef_value;
            r_in_res  <= i_residual;
        end
        if (res_fire) begin
            r_out_sample <= mac_out.sample;
            r_out_last   <= frame_end;
            r_out_clip   <= mac_out.clipped;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_sample     = r_out_sample;
    assign o_frame_last = r_out_last;
    assign o_clipped    = r_out_clip;

    // A frame-ending sample leaves a clean history and position behind
    a_frame_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_fire && frame_end |=> r_pos == '0 && r_hist[0] == '0)
        else $error("history not cleared at frame end");

    // A coefficient load never creates an output transaction
    a_coef_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && r_in_kind == KIND_COEF && !r_out_valid |=> !r_out_valid)
        else $error("coefficient load produced an output");

    // Back-pressure only when a residual waits on a stalled output
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_in_valid && r_in_kind == KIND_RES && r_out_valid && i_stall)
        else $error("input stalled without cause");

    // A held output keeps its sample until it is taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && i_stall |=> r_out_valid && $stable(r_out_sample))
        else $error("stalled output changed");

endmodule
